// ===== hw/rtl/assert_macros.svh =====
// -----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the stepper pulse generator checks
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SSPG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sspg assertion failed");

// clocked assertion that also holds during reset
`define SSPG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sspg assertion failed");

`endif

// ===== hw/rtl/sspg_pkg.sv =====
// -----------------------------------------------------------------------------
// sspg_pkg
// shared types and constants of the stepper step pulse generator
// -----------------------------------------------------------------------------
package sspg_pkg;

   localparam int POSITION_BITS  = 48;
   localparam int SPEED_BITS     = 17;
   localparam int MAG_BITS       = 16;
   localparam int HELD_BITS      = 18;
   localparam int COUNT_BITS     = 20;
   localparam int CSR_DATA_BITS  = 20;
   localparam int CSR_INDEX_BITS = 1;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS      = COUNT_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

   localparam logic [COUNT_BITS-1:0] MICROS_PER_SEC = 20'd1000000;

   localparam logic [MAG_BITS-1:0]   MAX_SPEED_RESET   = 16'd1000;
   localparam logic [COUNT_BITS-1:0] TICK_PERIOD_RESET = 20'd500;

   localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
   localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MAX_SPEED   = 1'b0,
      REG_TICK_PERIOD = 1'b1
   } sspg_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV_A  = 4'b0010,
      ST_DIV_B  = 4'b0100,
      ST_UPDATE = 4'b1000
   } sspg_state_type;

endpackage

// ===== hw/rtl/stepper_step_pulse_generator.sv =====
// -----------------------------------------------------------------------------
// stepper_step_pulse_generator: step/direction pulse generator, one motor
// a tick with unchanged speed: ST_UPDATE registers the word once the result register is free
// a nonzero speed change: two 20-step divider passes first; no new tick is taken until idle
// synchronous active-high reset: control and config registers to defaults, channels empty
// -----------------------------------------------------------------------------
module stepper_step_pulse_generator (
   input  logic                                     clock,
   input  logic                                     reset,
   // tick input channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [sspg_pkg::SPEED_BITS-1:0]   req_speed,
   input  logic                                     req_enable,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_step_level,
   output logic                                     rsp_direction,
   output logic signed [sspg_pkg::POSITION_BITS-1:0] rsp_position,
   output logic                                     rsp_awake,
   // register write channel
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sspg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [sspg_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   // sequencer
   sspg_pkg::sspg_state_type state_ff, state_in;

   // configuration registers
   logic [sspg_pkg::MAG_BITS-1:0]   max_speed_ff, max_speed_in;
   logic [sspg_pkg::COUNT_BITS-1:0] tick_us_ff, tick_us_in;

   // motor state
   logic signed [sspg_pkg::HELD_BITS-1:0]     held_speed_ff, held_speed_in;
   logic [sspg_pkg::COUNT_BITS-1:0]           tick_ff, tick_in;
   logic [sspg_pkg::COUNT_BITS-1:0]           period_ff, period_in;
   logic                                      dir_ff, dir_in;
   logic                                      pulse_ff, pulse_in;
   logic signed [sspg_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic                                      prev_en_ff, prev_en_in;
   logic                                      en_ff, en_in;

   // shared restoring divider
   logic [sspg_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [sspg_pkg::COUNT_BITS-1:0]   quo_ff, quo_in;
   logic [sspg_pkg::COUNT_BITS-1:0]   dsr_ff, dsr_in;
   logic [sspg_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   // result register
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic                                      rsp_step_ff, rsp_step_in;
   logic                                      rsp_dir_ff, rsp_dir_in;
   logic signed [sspg_pkg::POSITION_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic                                      rsp_awake_ff, rsp_awake_in;

   // speed limiting on the incoming word
   logic                                  spd_neg;
   logic [sspg_pkg::SPEED_BITS-1:0]       spd_mag;
   logic [sspg_pkg::MAG_BITS-1:0]         lim_mag;
   logic signed [sspg_pkg::HELD_BITS-1:0] lim_speed;

   // divider step
   logic [sspg_pkg::COUNT_BITS:0]   div_shift;
   logic [sspg_pkg::COUNT_BITS:0]   div_diff;
   logic                            div_ge;
   logic [sspg_pkg::COUNT_BITS-1:0] div_rem;
   logic [sspg_pkg::COUNT_BITS-1:0] div_quo;
   logic                            div_last;

   // tick counter
   logic [sspg_pkg::COUNT_BITS-1:0] cnt_base;
   logic [sspg_pkg::COUNT_BITS:0]   cnt_inc;
   logic [sspg_pkg::COUNT_BITS-1:0] cnt_new;
   logic                            moving;
   logic                            out_free;

   assign req_ready      = (state_ff == sspg_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_level = rsp_step_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_awake      = rsp_awake_ff;

   // magnitude clamp, both signs; -0 folds into 0
   always_comb begin
      spd_neg   = req_speed[sspg_pkg::SPEED_BITS-1];
      spd_mag   = spd_neg ? (sspg_pkg::SPEED_BITS'(0) - $unsigned(req_speed))
                          : $unsigned(req_speed);
      lim_mag   = (spd_mag > {1'b0, max_speed_ff}) ? max_speed_ff
                                                   : spd_mag[sspg_pkg::MAG_BITS-1:0];
      lim_speed = spd_neg ? -$signed({2'b00, lim_mag}) : $signed({2'b00, lim_mag});
   end

   // one restoring step: dividend bits shift out of quo, quotient bits shift in
   always_comb begin
      div_shift = {rem_ff, quo_ff[sspg_pkg::COUNT_BITS-1]};
      div_diff  = div_shift - {1'b0, dsr_ff};
      div_ge    = (div_shift >= {1'b0, dsr_ff});
      div_rem   = div_ge ? div_diff[sspg_pkg::COUNT_BITS-1:0]
                         : div_shift[sspg_pkg::COUNT_BITS-1:0];
      div_quo   = {quo_ff[sspg_pkg::COUNT_BITS-2:0], div_ge};
      div_last  = (cnt_ff == sspg_pkg::DIV_LAST);
   end

   // tick counter: rising enable restarts it, wraps once it passes the period
   always_comb begin
      cnt_base = (en_ff && !prev_en_ff) ? '0 : tick_ff;
      cnt_inc  = {1'b0, cnt_base} + 21'd1;
      cnt_new  = (cnt_inc > {1'b0, period_ff}) ? '0 : cnt_inc[sspg_pkg::COUNT_BITS-1:0];
      moving   = en_ff && (held_speed_ff != '0);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in      = state_ff;
      max_speed_in  = max_speed_ff;
      tick_us_in    = tick_us_ff;
      held_speed_in = held_speed_ff;
      tick_in       = tick_ff;
      period_in     = period_ff;
      dir_in        = dir_ff;
      pulse_in      = pulse_ff;
      pos_in        = pos_ff;
      prev_en_in    = prev_en_ff;
      en_in         = en_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_step_in   = rsp_step_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_awake_in  = rsp_awake_ff;

      // the user must write registers only while idle; the block itself does not enforce this
      if (csr_valid) begin
         case (csr_index)
            sspg_pkg::REG_MAX_SPEED:   max_speed_in = csr_wdata[sspg_pkg::MAG_BITS-1:0];
            sspg_pkg::REG_TICK_PERIOD: tick_us_in   = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         sspg_pkg::ST_IDLE: begin
            if (req_valid) begin
               en_in    = req_enable;
               state_in = sspg_pkg::ST_UPDATE;
               if (lim_speed != held_speed_ff) begin
                  held_speed_in = lim_speed;
                  if (lim_mag != '0) begin
                     // new speed: period = (1e6 / |speed|) / tick_us, two passes
                     dir_in   = !spd_neg;
                     rem_in   = '0;
                     quo_in   = sspg_pkg::MICROS_PER_SEC;
                     dsr_in   = {4'b0000, lim_mag};
                     cnt_in   = '0;
                     state_in = sspg_pkg::ST_DIV_A;
                  end
               end
            end
         end
         sspg_pkg::ST_DIV_A: begin
            rem_in = div_rem;
            quo_in = div_quo;
            cnt_in = cnt_ff + sspg_pkg::DIV_CNT_BITS'(1);
            if (div_last) begin
               // second pass divides the first quotient by the tick period
               rem_in   = '0;
               dsr_in   = (tick_us_ff == '0) ? 20'd1 : tick_us_ff;
               cnt_in   = '0;
               state_in = sspg_pkg::ST_DIV_B;
            end
         end
         sspg_pkg::ST_DIV_B: begin
            rem_in = div_rem;
            quo_in = div_quo;
            cnt_in = cnt_ff + sspg_pkg::DIV_CNT_BITS'(1);
            if (div_last) begin
               period_in = div_quo;
               state_in  = sspg_pkg::ST_UPDATE;
            end
         end
         sspg_pkg::ST_UPDATE: begin
            // waits only while the previous word still sits in the result register
            if (out_free) begin
               prev_en_in = en_ff;
               tick_in    = moving ? cnt_new : cnt_base;
               if (moving && (cnt_new == '0)) begin
                  pulse_in = 1'b1;
                  if (dir_ff) begin
                     pos_in = (pos_ff != sspg_pkg::POS_MAX)
                              ? pos_ff + sspg_pkg::POSITION_BITS'(1) : pos_ff;
                  end else begin
                     pos_in = (pos_ff != sspg_pkg::POS_MIN)
                              ? pos_ff - sspg_pkg::POSITION_BITS'(1) : pos_ff;
                  end
               end else if (moving && (cnt_new == 20'd1)) begin
                  pulse_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_step_in  = pulse_in;
               rsp_dir_in   = dir_ff;
               rsp_pos_in   = pos_in;
               rsp_awake_in = en_ff;
               state_in     = sspg_pkg::ST_IDLE;
            end
         end
         default: state_in = sspg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sspg_pkg::ST_IDLE;
         max_speed_ff  <= sspg_pkg::MAX_SPEED_RESET;
         tick_us_ff    <= sspg_pkg::TICK_PERIOD_RESET;
         held_speed_ff <= '0;
         tick_ff       <= '0;
         period_ff     <= '0;
         dir_ff        <= 1'b0;
         pulse_ff      <= 1'b0;
         pos_ff        <= '0;
         prev_en_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_speed_ff  <= max_speed_in;
         tick_us_ff    <= tick_us_in;
         held_speed_ff <= held_speed_in;
         tick_ff       <= tick_in;
         period_ff     <= period_in;
         dir_ff        <= dir_in;
         pulse_ff      <= pulse_in;
         pos_ff        <= pos_in;
         prev_en_ff    <= prev_en_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and divider datapath, no reset
   always_ff @(posedge clock) begin
      en_ff        <= en_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dsr_ff       <= dsr_in;
      cnt_ff       <= cnt_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_awake_ff <= rsp_awake_in;
   end

endmodule

// ===== hw/rtl/sspg_checker.sv =====
// -----------------------------------------------------------------------------
// sspg_checker
// port-level checks of the stepper step pulse generator, bound to the top
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module sspg_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic                                      rsp_step_level,
   input logic                                      rsp_direction,
   input logic signed [sspg_pkg::POSITION_BITS-1:0] rsp_position,
   input logic                                      rsp_awake
);

   logic                               req_fire;
   logic                               rsp_stall;
   logic [sspg_pkg::POSITION_BITS+2:0] rsp_word;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_step_level, rsp_direction, rsp_position, rsp_awake};

   // result register comes out of reset empty
   `SSPG_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, reset |=> !rsp_valid)

   // one word in flight: the input closes right after a word is taken
   `SSPG_ASSERT(a_busy_after_accept, clock, reset, req_fire |=> !req_ready)

   // a stalled word stays offered
   `SSPG_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid)

   // a stalled word keeps its payload
   `SSPG_ASSERT(a_rsp_stable, clock, reset, rsp_stall |=> $stable(rsp_word))

endmodule

bind stepper_step_pulse_generator sspg_checker u_sspg_checker (.*);

// ===== dv/tb.sv =====
// -----------------------------------------------------------------------------
// tb: stepper step pulse generator testbench
// plays timer ticks and register writes into the block and predicts every
// result word with a local motor model, with random idling on both channels
// -----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 600000;
   // once this few plan entries remain, both sides stop idling
   localparam int CALM_ENTRIES = 120;
   // cycles to watch for stray words once everything has come back
   localparam int TAIL_CYCLES = 60;

   typedef enum logic [1:0] {
      ENT_TICK,
      ENT_CSR,
      ENT_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type                          kind;
      logic signed [sspg_pkg::SPEED_BITS-1:0] speed;
      logic                                   enable;
      sspg_pkg::sspg_reg_type                 index;
      logic [sspg_pkg::CSR_DATA_BITS-1:0]     data;
   } plan_entry_type;

   typedef struct {
      logic                                      step_level;
      logic                                      direction;
      logic signed [sspg_pkg::POSITION_BITS-1:0] position;
      logic                                      awake;
   } tick_result_type;

   // clock, reset and block ports; every input starts at a known value
   logic                                      clock = 1'b0;
   logic                                      reset = 1'b1;
   logic                                      req_valid = 1'b0;
   logic                                      req_ready;
   logic signed [sspg_pkg::SPEED_BITS-1:0]    req_speed = '0;
   logic                                      req_enable = 1'b0;
   logic                                      rsp_valid;
   logic                                      rsp_ready = 1'b0;
   logic                                      rsp_step_level;
   logic                                      rsp_direction;
   logic signed [sspg_pkg::POSITION_BITS-1:0] rsp_position;
   logic                                      rsp_awake;
   logic                                      csr_valid = 1'b0;
   logic                                      csr_ready;
   sspg_pkg::sspg_reg_type                    csr_index = sspg_pkg::REG_MAX_SPEED;
   logic [sspg_pkg::CSR_DATA_BITS-1:0]        csr_wdata = '0;

   // stimulus plan and the results still due
   plan_entry_type                            command_plan[$];
   tick_result_type                           due_results[$];
   int                                        words_sent = 0;
   int                                        words_seen = 0;
   logic                                      calm = 1'b0;
   bit                                        failed = 1'b0;
   int                                        cycle_count = 0;
   int                                        gap_left = 0;
   int                                        stall_left = 0;

   // motor model: configuration copy and state
   logic [sspg_pkg::MAG_BITS-1:0]             speed_cap;
   logic [sspg_pkg::COUNT_BITS-1:0]           tick_div;
   logic signed [sspg_pkg::HELD_BITS-1:0]     held_rate;
   logic [sspg_pkg::COUNT_BITS-1:0]           tick_ctr;
   logic [sspg_pkg::COUNT_BITS-1:0]           period_len;
   logic                                      dir_cw;
   logic                                      pulse_out;
   logic signed [sspg_pkg::POSITION_BITS-1:0] motor_pos;
   logic                                      was_enabled;

   stepper_step_pulse_generator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_speed      (req_speed),
      .req_enable     (req_enable),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_level (rsp_step_level),
      .rsp_direction  (rsp_direction),
      .rsp_position   (rsp_position),
      .rsp_awake      (rsp_awake),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // one timer tick through the motor model, returns the word it should produce
   function automatic tick_result_type advance_motor(
      input logic signed [sspg_pkg::SPEED_BITS-1:0] spd,
      input logic                                   en);
      logic                                  neg;
      logic [sspg_pkg::SPEED_BITS-1:0]       mag;
      logic signed [sspg_pkg::HELD_BITS-1:0] lim;
      int unsigned                           quot;
      int unsigned                           divisor;
      logic [sspg_pkg::COUNT_BITS:0]         nxt;
      tick_result_type                       res;
      neg = spd[sspg_pkg::SPEED_BITS-1];
      mag = neg ? -spd : spd;
      // magnitude clamp, so negative speeds are limited too
      if (mag > {1'b0, speed_cap})
         mag = {1'b0, speed_cap};
      lim = sspg_pkg::HELD_BITS'(mag);
      if (neg)
         lim = -lim;
      // a new nonzero speed sets period and direction, zero keeps both
      if (lim != held_rate) begin
         held_rate = lim;
         if (mag != 0) begin
            divisor = (tick_div == 0) ? 1 : 32'(tick_div);
            quot = 32'(sspg_pkg::MICROS_PER_SEC) / 32'(mag);
            quot = quot / divisor;
            period_len = quot[sspg_pkg::COUNT_BITS-1:0];
            dir_cw = !neg;
         end
      end
      // waking up restarts the count
      if (en && !was_enabled)
         tick_ctr = '0;
      was_enabled = en;
      if (en && held_rate != 0) begin
         nxt = {1'b0, tick_ctr} + (sspg_pkg::COUNT_BITS + 1)'(1);
         if (nxt > {1'b0, period_len})
            nxt = '0;
         tick_ctr = nxt[sspg_pkg::COUNT_BITS-1:0];
         if (tick_ctr == 0) begin
            pulse_out = 1'b1;
            // position sticks at either end of its range
            if (dir_cw) begin
               if (motor_pos != sspg_pkg::POS_MAX)
                  motor_pos = motor_pos + sspg_pkg::POSITION_BITS'(1);
            end else if (motor_pos != sspg_pkg::POS_MIN) begin
               motor_pos = motor_pos - sspg_pkg::POSITION_BITS'(1);
            end
         end else if (tick_ctr == 1) begin
            pulse_out = 1'b0;
         end
      end
      res.step_level = pulse_out;
      res.direction  = dir_cw;
      res.position   = motor_pos;
      res.awake      = en;
      return res;
   endfunction

   function automatic void check_field(input string what, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         failed = 1'b1;
      end
   endfunction

   task automatic plan_tick(input int spd, input logic en);
      plan_entry_type e;
      e.kind   = ENT_TICK;
      e.speed  = sspg_pkg::SPEED_BITS'(spd);
      e.enable = en;
      e.index  = sspg_pkg::REG_MAX_SPEED;
      e.data   = '0;
      command_plan.push_back(e);
   endtask

   task automatic plan_drain();
      plan_entry_type e;
      e.kind   = ENT_DRAIN;
      e.speed  = '0;
      e.enable = 1'b0;
      e.index  = sspg_pkg::REG_MAX_SPEED;
      e.data   = '0;
      command_plan.push_back(e);
   endtask

   // settings change only with nothing in flight
   task automatic plan_settings(input int unsigned cap, input int unsigned period_us);
      plan_entry_type e;
      plan_drain();
      e.kind   = ENT_CSR;
      e.speed  = '0;
      e.enable = 1'b0;
      e.index  = sspg_pkg::REG_MAX_SPEED;
      e.data   = sspg_pkg::CSR_DATA_BITS'(cap);
      command_plan.push_back(e);
      e.index  = sspg_pkg::REG_TICK_PERIOD;
      e.data   = sspg_pkg::CSR_DATA_BITS'(period_us);
      command_plan.push_back(e);
   endtask

   // mostly held speeds with the driver awake, so the counter runs through
   // whole periods; some enable flicker and per-tick random speeds as noise
   task automatic plan_motion(input int n, input int unsigned cap);
      int          done;
      int          seg_len;
      int unsigned mag;
      int          spd;
      logic        en;
      bit          noisy;
      done = 0;
      while (done < n) begin
         noisy = ($urandom_range(0, 9) == 0);
         seg_len = noisy ? $urandom_range(1, 6) : $urandom_range(1, 30);
         en = ($urandom_range(0, 6) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: mag = cap + $urandom_range(0, 200);
            5, 6:          mag = $urandom_range(0, 65535);
            7:             mag = 0;
            8:             mag = $urandom_range(1, (cap > 1) ? cap : 1);
            default:       mag = 65535;
         endcase
         if (mag > 65535)
            mag = 65535;
         spd = $urandom_range(0, 1) ? -int'(mag) : int'(mag);
         for (int k = 0; k < seg_len && done < n; k++) begin
            if (noisy)
               spd = int'($urandom_range(0, 131070)) - 65535;
            if ($urandom_range(0, 19) == 0)
               en = !en;
            plan_tick(spd, en);
            done++;
         end
      end
   endtask

   // driver: feeds ticks and register writes, runs the model on each accept
   always @(posedge clock) begin : drive_commands
      plan_entry_type e;
      logic           req_hold;
      logic           csr_hold;
      if (reset) begin
         req_valid   <= 1'b0;
         csr_valid   <= 1'b0;
         gap_left    = 0;
         speed_cap   = sspg_pkg::MAX_SPEED_RESET;
         tick_div    = sspg_pkg::TICK_PERIOD_RESET;
         held_rate   = '0;
         tick_ctr    = '0;
         period_len  = '0;
         dir_cw      = 1'b0;
         pulse_out   = 1'b0;
         motor_pos   = '0;
         was_enabled = 1'b0;
      end else begin
         req_hold = req_valid && !req_ready;
         csr_hold = csr_valid && !csr_ready;
         if (req_valid && req_ready) begin
            due_results.push_back(advance_motor(req_speed, req_enable));
            words_sent <= words_sent + 1;
            if (!calm && $urandom_range(0, 5) == 0)
               gap_left = $urandom_range(1, 16);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sspg_pkg::REG_MAX_SPEED:   speed_cap = csr_wdata[sspg_pkg::MAG_BITS-1:0];
               sspg_pkg::REG_TICK_PERIOD: tick_div  = csr_wdata;
               default: ;
            endcase
         end
         if (!req_hold && !csr_hold) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (command_plan.size() != 0) begin
               e = command_plan[0];
               case (e.kind)
                  ENT_TICK: begin
                     req_hold = 1'b1;
                     req_speed  <= e.speed;
                     req_enable <= e.enable;
                     void'(command_plan.pop_front());
                  end
                  ENT_CSR: begin
                     csr_hold = 1'b1;
                     csr_index <= e.index;
                     csr_wdata <= e.data;
                     void'(command_plan.pop_front());
                  end
                  default: begin
                     // hold off until every word sent has come back
                     if (!(req_valid && req_ready) && words_sent == words_seen)
                        void'(command_plan.pop_front());
                  end
               endcase
            end
         end
         req_valid <= req_hold;
         csr_valid <= csr_hold;
         calm      <= (command_plan.size() < CALM_ENTRIES);
      end
   end

   // monitor: checks each result word against the oldest prediction
   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen <= words_seen + 1;
            if (due_results.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               failed = 1'b1;
            end else begin
               want = due_results.pop_front();
               check_field("step_level", longint'(want.step_level),
                           longint'(rsp_step_level));
               check_field("direction", longint'(want.direction),
                           longint'(rsp_direction));
               check_field("position", longint'(want.position), longint'(rsp_position));
               check_field("awake", longint'(want.awake), longint'(rsp_awake));
            end
         end
         if (stall_left != 0)
            stall_left--;
         else if (!calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 16);
         rsp_ready <= (stall_left == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words due", $time, due_results.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      // directed part at the reset settings: cap 1000, 500 us ticks, period 2
      plan_tick(0, 1'b0);
      plan_tick(0, 1'b1);
      repeat (4) plan_tick(1000, 1'b1);
      // over the cap on both sides
      repeat (2) plan_tick(65535, 1'b1);
      repeat (3) plan_tick(-1000, 1'b1);
      repeat (2) plan_tick(-65535, 1'b1);
      // zero speed keeps period and direction
      repeat (2) plan_tick(0, 1'b1);
      // new speed while asleep, then wake up with the counter cleared
      repeat (2) plan_tick(500, 1'b0);
      repeat (3) plan_tick(500, 1'b1);
      // slowest speed gives a long period
      repeat (2) plan_tick(1, 1'b1);
      plan_tick(-1, 1'b1);
      plan_tick(65535, 1'b0);

      plan_motion(100, 1000);
      // widest cap, shortest tick
      plan_settings(65535, 1);
      plan_motion(125, 65535);
      // smallest nonzero cap, longest tick
      plan_settings(1, 1000000);
      plan_motion(125, 1);
      plan_settings(5000, 100);
      plan_motion(60, 5000);
      // pause with nothing else going on
      plan_drain();
      plan_motion(65, 5000);
      // zero tick period counts as one
      plan_settings(40000, 0);
      plan_motion(125, 40000);
      // zero cap stops everything
      plan_settings(0, 300);
      plan_motion(40, 0);
      // mostly zero periods: a step on every tick
      plan_settings(65535, 200000);
      plan_motion(125, 65535);
      plan_settings(300, 1000);
      plan_motion(125, 300);
      plan_settings(1000, 500);
      plan_motion(125, 1000);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (command_plan.size() != 0 || words_sent != words_seen || req_valid || csr_valid)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         $display("%0t: %0d expected words never came", $time, due_results.size());
         failed = 1'b1;
      end
      if (!failed)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sspg_pkg.sv
hw/rtl/stepper_step_pulse_generator.sv
hw/rtl/sspg_checker.sv
dv/tb.sv
